FILE: rtl/slcd_pkg.sv
// Package for the sync/length/command deframer: phase and result codes,
// the result record carried between the parser, the queue and the output stage.
// Depends on nothing.
`default_nettype none

package slcd_pkg;

  localparam logic [7:0]  SYNC_FIRST        = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND       = 8'hFE;
  localparam logic [31:0] HEADER_BYTES      = 32'd4;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4086;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMD  = 3'd2,
    PH_PAY  = 3'd3,
    PH_SUM  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADSUM  = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] command;
    logic [15:0] length;
    logic        eop;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/slcd_front.sv
// Parser front end: sync hunt, length and command capture, checksum compare.
// Produces at most one result record per accepted byte. Uses slcd_pkg.
`default_nettype none

module slcd_front
  import slcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  stream_byte,
  input  logic        abort_frame,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase;
  phase_t      phase_next;
  logic        saw_first;
  logic [15:0] count;
  logic [23:0] len_lo;
  logic [15:0] plen;
  logic [15:0] cmd;
  logic [15:0] run_sum;
  logic [7:0]  recv_lo;
  logic [15:0] max_payload;

  logic [31:0] len_full;
  logic [31:0] len_diff;
  logic        len_short;
  logic        len_over;
  logic        len_last;
  logic        len_reject;
  logic [15:0] count_inc;
  logic        pay_done;
  logic        sync_hit;
  logic        sum_done;
  logic        clear_frame;
  logic        hunting;

  assign len_full   = {stream_byte, len_lo};
  assign len_diff   = len_full - HEADER_BYTES;
  assign len_short  = len_full < HEADER_BYTES;
  assign len_over   = len_diff > {16'b0, max_payload};
  assign len_last   = (count[1:0] == 2'd3);
  assign len_reject = len_last && (len_short || len_over);
  assign count_inc  = count + 16'd1;
  assign pay_done   = count_inc >= plen;
  assign sync_hit   = saw_first && (stream_byte == SYNC_SECOND);
  assign sum_done   = count[0];
  assign hunting    = !(phase == PH_LEN || phase == PH_CMD || phase == PH_PAY ||
                        phase == PH_SUM);

  assign clear_frame = accept && (abort_frame ||
                       (phase == PH_LEN && len_reject) ||
                       (phase == PH_SUM && sum_done) ||
                       (hunting && sync_hit));

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (abort_frame) begin
        phase_next = PH_HUNT;
      end else begin
        unique case (phase)
          PH_LEN: begin
            if (len_last) phase_next = len_reject ? PH_HUNT : PH_CMD;
          end
          PH_CMD: begin
            if (count[0]) phase_next = (plen == 16'd0) ? PH_SUM : PH_PAY;
          end
          PH_PAY: begin
            if (pay_done) phase_next = PH_SUM;
          end
          PH_SUM: begin
            if (sum_done) phase_next = PH_HUNT;
          end
          default: begin
            phase_next = sync_hit ? PH_LEN : PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid   = 1'b0;
    res.kind    = KIND_PAYLOAD;
    res.data    = 8'd0;
    res.command = 16'd0;
    res.length  = 16'd0;
    res.eop     = 1'b0;
    if (accept && !abort_frame) begin
      unique case (phase)
        PH_LEN: begin
          if (len_reject) begin
            res_valid = 1'b1;
            res.kind  = KIND_REJECT;
            res.eop   = 1'b1;
            if (len_short) begin
              res.length = 16'd0;
            end else if (len_diff[31:16] != 16'd0) begin
              res.length = 16'hFFFF;
            end else begin
              res.length = len_diff[15:0];
            end
          end
        end
        PH_PAY: begin
          res_valid   = 1'b1;
          res.kind    = KIND_PAYLOAD;
          res.data    = stream_byte;
          res.command = cmd;
          res.length  = plen;
        end
        PH_SUM: begin
          if (sum_done) begin
            res_valid   = 1'b1;
            res.kind    = ({stream_byte, recv_lo} == run_sum) ? KIND_GOOD : KIND_BADSUM;
            res.command = cmd;
            res.length  = plen;
            res.eop     = 1'b1;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      saw_first   <= 1'b0;
      count       <= 16'd0;
      len_lo      <= 24'd0;
      plen        <= 16'd0;
      cmd         <= 16'd0;
      run_sum     <= 16'd0;
      recv_lo     <= 8'd0;
      max_payload <= MAX_PAYLOAD_RESET;
    end else begin
      phase <= phase_next;
      if (cfg_valid) max_payload <= cfg_data;
      if (clear_frame) begin
        saw_first <= 1'b0;
        count     <= 16'd0;
        len_lo    <= 24'd0;
        plen      <= 16'd0;
        cmd       <= 16'd0;
        run_sum   <= 16'd0;
        recv_lo   <= 8'd0;
      end else if (accept) begin
        unique case (phase)
          PH_LEN: begin
            unique case (count[1:0])
              2'd0: len_lo[7:0]   <= stream_byte;
              2'd1: len_lo[15:8]  <= stream_byte;
              2'd2: len_lo[23:16] <= stream_byte;
              default: plen       <= len_diff[15:0];
            endcase
            count <= len_last ? 16'd0 : count_inc;
          end
          PH_CMD: begin
            if (count[0]) begin
              cmd[15:8] <= stream_byte;
              count     <= 16'd0;
            end else begin
              cmd[7:0] <= stream_byte;
              count    <= 16'd1;
            end
          end
          PH_PAY: begin
            run_sum <= run_sum + {8'd0, stream_byte};
            count   <= pay_done ? 16'd0 : count_inc;
          end
          PH_SUM: begin
            recv_lo <= stream_byte;
            count   <= 16'd1;
          end
          default: begin
            saw_first <= (stream_byte == SYNC_FIRST);
          end
        endcase
      end
    end
  end

  // An abort always lands the parser back in the hunt with a cleared sum.
  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    accept && abort_frame |=> phase == PH_HUNT && run_sum == 16'd0 && count == 16'd0)
    else $error("abort did not clear the frame state");

  // The payload counter never runs past the payload length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> count < plen)
    else $error("payload count beyond payload length");

endmodule

`default_nettype wire

FILE: rtl/slcd_fifo.sv
// Short result queue between the parser and the output stage.
// Register array with read and write pointers. Uses slcd_pkg.
`default_nettype none

module slcd_fifo
  import slcd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    is_full,
  output logic    is_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  result_t       mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      if (rd_en) rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |-> !is_full)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !is_empty)
    else $error("read from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == $past(count) + CW'(1))
    else $error("queue count did not advance on a write");

endmodule

`default_nettype wire

FILE: rtl/slcd_back.sv
// Output stage: holds the oldest result and refills from the queue.
// Uses slcd_pkg.
`default_nettype none

module slcd_back
  import slcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  result_t q_data,
  output logic    q_rd,
  input  logic    pop,
  output logic    out_valid,
  output result_t out_data
);

  logic load;

  assign load = !q_empty && (!out_valid || pop);
  assign q_rd = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= q_data;
  end

endmodule

`default_nettype wire

FILE: rtl/sync_length_command_deframer_unit.sv
// Top level of the sync/length/command deframer: parser, result queue, output stage.
// Depends on slcd_pkg, slcd_front, slcd_fifo and slcd_back.
//
//   channel   handshake               payload
//   input     push / full             stream_byte, abort_frame
//   result    empty / pop             result_kind, payload_byte, packet_command,
//                                     payload_length, end_of_packet
//   config    cfg_valid / cfg_ready   cfg_data (max_payload_bytes)
//
// One byte beat is accepted per cycle while full is low; the parser handles it in that cycle.
// A result enters the result queue at the edge that accepts its byte, then moves into the output register.
// full rises only when the result queue is full; cfg_ready is always high.
// Reset returns the parser to the sync hunt and sets the payload limit to 4086.
`default_nettype none

module sync_length_command_deframer_unit
  import slcd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte,
  input  logic        abort_frame,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] packet_command,
  output logic [15:0] payload_length,
  output logic        end_of_packet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    q_full;
  logic    q_empty;
  logic    q_rd;
  result_t q_data;
  logic    out_valid;
  result_t out_data;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  slcd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .stream_byte (stream_byte),
    .abort_frame (abort_frame),
    .res_valid   (res_valid),
    .res         (res)
  );

  slcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .is_full  (q_full),
    .is_empty (q_empty)
  );

  slcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign empty          = !out_valid;
  assign result_kind    = out_data.kind;
  assign payload_byte   = out_data.data;
  assign packet_command = out_data.command;
  assign payload_length = out_data.length;
  assign end_of_packet  = out_data.eop;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for sync_length_command_deframer_unit: a directed frame table, then
// random frames under several payload limits and idle patterns, checked beat by beat.
// Depends on slcd_pkg and the deframer RTL.
module testbench;
  import slcd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_BEATS = 340;
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic [7:0] data;
    logic       abort;
    bit         typed;
    result_t    want;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  stream_byte = '0;
  logic        abort_frame = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] packet_command;
  logic [15:0] payload_length;
  logic        end_of_packet;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  phase_t      ph;
  logic        saw_ff;
  logic [15:0] field_count;
  logic [31:0] length_acc;
  logic [15:0] command_acc;
  logic [15:0] payload_sum;
  logic [15:0] checksum_acc;
  logic [15:0] limit_bytes;
  result_t     expected_results[$];
  int          failures = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;

  sync_length_command_deframer_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .stream_byte(stream_byte),
    .abort_frame(abort_frame),
    .empty(empty),
    .pop(pop),
    .result_kind(result_kind),
    .payload_byte(payload_byte),
    .packet_command(packet_command),
    .payload_length(payload_length),
    .end_of_packet(end_of_packet),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_frame_state();
    ph = PH_HUNT;
    saw_ff = 1'b0;
    field_count = '0;
    length_acc = '0;
    command_acc = '0;
    payload_sum = '0;
    checksum_acc = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic abort,
                                      output result_t r);
    logic [31:0] body;
    bit got;
    got = 1'b0;
    r = '0;
    body = length_acc - 32'd4;
    if (abort) begin
      clear_frame_state();
    end else begin
      case (ph)
        PH_LEN: begin
          length_acc = length_acc | ({24'd0, b} << (8 * field_count[1:0]));
          field_count = field_count + 16'd1;
          if (field_count == 16'd4) begin
            body = length_acc - 32'd4;
            if (length_acc < 32'd4) begin
              r.kind = KIND_REJECT;
              r.eop = 1'b1;
              got = 1'b1;
              clear_frame_state();
            end else if (body > {16'd0, limit_bytes}) begin
              r.kind = KIND_REJECT;
              r.length = (body > 32'hFFFF) ? 16'hFFFF : body[15:0];
              r.eop = 1'b1;
              got = 1'b1;
              clear_frame_state();
            end else begin
              ph = PH_CMD;
              field_count = '0;
            end
          end
        end
        PH_CMD: begin
          command_acc = command_acc | ({8'd0, b} << (8 * field_count[0]));
          field_count = field_count + 16'd1;
          if (field_count == 16'd2) begin
            field_count = '0;
            ph = (length_acc == 32'd4) ? PH_SUM : PH_PAY;
          end
        end
        PH_PAY: begin
          payload_sum = payload_sum + {8'd0, b};
          field_count = field_count + 16'd1;
          r.kind = KIND_PAYLOAD;
          r.data = b;
          r.command = command_acc;
          r.length = body[15:0];
          got = 1'b1;
          if (field_count >= body[15:0]) begin
            field_count = '0;
            ph = PH_SUM;
          end
        end
        PH_SUM: begin
          checksum_acc = checksum_acc | ({8'd0, b} << (8 * field_count[0]));
          field_count = field_count + 16'd1;
          if (field_count == 16'd2) begin
            r.kind = (checksum_acc == payload_sum) ? KIND_GOOD : KIND_BADSUM;
            r.command = command_acc;
            r.length = body[15:0];
            r.eop = 1'b1;
            got = 1'b1;
            clear_frame_state();
          end
        end
        default: begin
          if (b == SYNC_FIRST) begin
            saw_ff = 1'b1;
          end else if (saw_ff && b == SYNC_SECOND) begin
            clear_frame_state();
            ph = PH_LEN;
          end else begin
            saw_ff = 1'b0;
          end
        end
      endcase
    end
    return got;
  endfunction

  function automatic frame_row_t beat_row(input logic [7:0] b, input logic abort);
    beat_row = '{b, abort, 1'b0, '0};
  endfunction

  function automatic frame_row_t typed_row(input logic [7:0] b, input kind_t kind,
                                           input logic [7:0] data, input logic [15:0] command,
                                           input logic [15:0] length, input logic eop);
    typed_row = '{b, 1'b0, 1'b1, '{kind, data, command, length, eop}};
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic abort, input bit typed,
                           input result_t want);
    result_t r;
    bit got;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    stream_byte <= b;
    abort_frame <= abort;
    do @(posedge clk); while (full);
    got = deframe_byte(b, abort, r);
    if (typed)
      expected_results.push_back(want);
    else if (got)
      expected_results.push_back(r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_bytes = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One frame: some noise, a sync pair, then a length that is usually acceptable and
  // sometimes too short, just over the limit or huge. Some frames are cut by an abort.
  task automatic send_packet(inout int sent);
    logic [8:0]  beats[$];
    logic [31:0] len;
    logic [15:0] sum;
    logic [7:0]  v;
    int          cls;
    int          pay_len;
    int          cut;
    int          i;
    for (i = $urandom_range(3); i > 0; i--) begin
      v = 8'($urandom);
      if ($urandom_range(3) == 0)
        v = SYNC_FIRST;
      beats.push_back({1'b0, v});
    end
    if ($urandom_range(3) == 0)
      beats.push_back({1'b0, SYNC_FIRST});
    beats.push_back({1'b0, SYNC_FIRST});
    beats.push_back({1'b0, SYNC_SECOND});
    cls = $urandom_range(99);
    pay_len = 0;
    if (cls < 70) begin
      pay_len = ($urandom_range(39) == 0) ? $urandom_range(300) : $urandom_range(12);
      if (pay_len > limit_bytes)
        pay_len = limit_bytes;
      len = pay_len + 4;
    end else if (cls < 78) begin
      len = $urandom_range(3);
    end else if (cls < 88) begin
      len = {16'd0, limit_bytes} + 32'd5 + $urandom_range(3);
    end else begin
      len = $urandom | 32'h0010_0000;
    end
    for (i = 0; i < 4; i++)
      beats.push_back({1'b0, len[8 * i +: 8]});
    if (cls < 70) begin
      v = 8'($urandom);
      beats.push_back({1'b0, v});
      v = 8'($urandom);
      beats.push_back({1'b0, v});
      sum = '0;
      for (i = 0; i < pay_len; i++) begin
        v = 8'($urandom);
        sum = sum + {8'd0, v};
        beats.push_back({1'b0, v});
      end
      if ($urandom_range(4) == 0)
        sum = 16'($urandom);
      beats.push_back({1'b0, sum[7:0]});
      beats.push_back({1'b0, sum[15:8]});
    end
    if ($urandom_range(11) == 0) begin
      cut = $urandom_range(beats.size() - 1);
      while (beats.size() > cut)
        void'(beats.pop_back());
      v = 8'($urandom);
      beats.push_back({1'b1, v});
    end
    foreach (beats[k])
      send_beat(beats[k][7:0], beats[k][8], 1'b0, '0);
    sent += beats.size();
  endtask

  always @(negedge clk) pop <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        if (failures < 10)
          $display("unexpected result: kind %0d byte %02h cmd %04h len %0d eop %0b",
                   result_kind, payload_byte, packet_command, payload_length, end_of_packet);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (result_kind !== want.kind || payload_byte !== want.data ||
            packet_command !== want.command || payload_length !== want.length ||
            end_of_packet !== want.eop) begin
          if (failures < 10)
            $display("mismatch: expected kind %0d byte %02h cmd %04h len %0d eop %0b, %s",
                     want.kind, want.data, want.command, want.length, want.eop,
                     $sformatf("got kind %0d byte %02h cmd %04h len %0d eop %0b",
                               result_kind, payload_byte, packet_command,
                               payload_length, end_of_packet));
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("** sync_length_command_deframer_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    frame_row_t  rows[$];
    logic [15:0] limits[NUM_PHASES];
    int          p;
    int          sent;
    clear_frame_state();
    limit_bytes = MAX_PAYLOAD_RESET;
    tx_idle_pct = 21;
    rx_idle_pct = 86;

    // Doubled first sync byte, then a length of zero.
    rows.push_back(beat_row(8'hFF, 1'b0));  rows.push_back(beat_row(8'hFF, 1'b0));
    rows.push_back(beat_row(8'hFE, 1'b0));  rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(beat_row(8'h00, 1'b0));  rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(typed_row(8'h00, KIND_REJECT, 8'h00, 16'h0000, 16'd0, 1'b1));
    // Empty payload with command 0xFFFF and a zero checksum.
    rows.push_back(beat_row(8'hFF, 1'b0));  rows.push_back(beat_row(8'hFE, 1'b0));
    rows.push_back(beat_row(8'h04, 1'b0));  rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(beat_row(8'h00, 1'b0));  rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(beat_row(8'hFF, 1'b0));  rows.push_back(beat_row(8'hFF, 1'b0));
    rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(typed_row(8'h00, KIND_GOOD, 8'h00, 16'hFFFF, 16'd0, 1'b1));
    // One payload byte, then the frame is aborted before its checksum.
    rows.push_back(beat_row(8'hFF, 1'b0));  rows.push_back(beat_row(8'hFE, 1'b0));
    rows.push_back(beat_row(8'h05, 1'b0));  rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(beat_row(8'h00, 1'b0));  rows.push_back(beat_row(8'h00, 1'b0));
    rows.push_back(beat_row(8'h34, 1'b0));  rows.push_back(beat_row(8'h12, 1'b0));
    rows.push_back(typed_row(8'h80, KIND_PAYLOAD, 8'h80, 16'h1234, 16'd1, 1'b0));
    rows.push_back(beat_row(8'h5A, 1'b1));

    limits[0] = 16'hFFFF;
    limits[1] = 16'd0;
    limits[2] = 16'd40;
    limits[3] = 16'($urandom_range(1, 300));
    limits[4] = 16'd7;
    limits[5] = MAX_PAYLOAD_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_beat(rows[i].data, rows[i].abort, rows[i].typed, rows[i].want);

    for (p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct = (p < 2) ? 21 : (p < 4) ? 86 : 0;
      rx_idle_pct = (p < 2) ? 86 : (p < 4) ? 21 : 0;
      write_limit(limits[p]);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        send_packet(sent);
        if ($urandom_range(49) == 0)
          drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("** sync_length_command_deframer_unit: PASSED **");
    end else begin
      $display("** sync_length_command_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
